@@ src/aar_pkg.sv @@
// Package for the axis-angle rotation matrix: constants, payload types and arithmetic helpers.
`default_nettype none
package aar_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 14;
	localparam int SQRT_CELLS   = 32;
	localparam int DIV_CELLS    = 31;
	localparam int OUT_STAGES   = 4;
	localparam int OUT_SH       = 30 - FRAC_BITS;

	localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
	localparam logic signed [32:0] PI_Q30      = 33'sd3373259426;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;
	localparam logic signed [39:0] OUT_ROUND   =
		(OUT_SH > 0) ? (40'sd1 <<< ((OUT_SH > 0) ? OUT_SH - 1 : 0)) : 40'sd0;
	localparam logic signed [39:0] OUT_LIM     = 40'sd1 <<< FRAC_BITS;

	// axis data carried along the square root chain
	typedef struct packed {
		logic signed [32:0] ang;
		logic               neg;
		logic               zero;
		logic [2:0]         sgn;
		logic [2:0][15:0]   mag;
	} side_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [31:0] rad;
	} sqrt_t;

	typedef struct packed {
		logic [31:0]       r;
		logic [2:0][32:0]  p;
		logic [2:0][30:0]  q;
	} div_t;

	typedef struct packed {
		logic signed [32:0] ang;
		logic               neg;
		logic               zero;
		logic [2:0]         sgn;
	} dside_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} cord_t;

	typedef struct packed {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic               neg;
		logic               zero;
	} cside_t;

	function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
		logic signed [32:0] v;
		unique case (i)
			5'd0:    v = 33'sd843314857;
			5'd1:    v = 33'sd497837829;
			5'd2:    v = 33'sd263043837;
			5'd3:    v = 33'sd133525159;
			5'd4:    v = 33'sd67021687;
			5'd5:    v = 33'sd33543516;
			5'd6:    v = 33'sd16775851;
			5'd7:    v = 33'sd8388437;
			5'd8:    v = 33'sd4194283;
			5'd9:    v = 33'sd2097149;
			default: v = 33'sd1 <<< (5'd30 - i);
		endcase
		return v;
	endfunction

	// Q2.30 product with floor shift
	function automatic logic signed [38:0] mulq(input logic signed [36:0] a,
		input logic signed [31:0] b);
		logic signed [68:0] p;
		p = a * b;
		return p[68:30];
	endfunction

	function automatic logic [15:0] to_out(input logic signed [39:0] v);
		logic signed [39:0] w;
		w = (v + OUT_ROUND) >>> OUT_SH;
		if (w > OUT_LIM)
			w = OUT_LIM;
		else if (w < -OUT_LIM)
			w = -OUT_LIM;
		return w[15:0];
	endfunction

endpackage
`default_nettype wire

@@ src/aar_sqrt_cell.sv @@
// One digit of the integer square root of the axis norm.
`default_nettype none
module aar_sqrt_cell import aar_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_vld,
	input  wire sqrt_t in_sq,
	input  wire side_t in_side,
	output logic       out_vld,
	output sqrt_t      out_sq,
	output side_t      out_side
);
	logic [35:0] rem2;
	logic [35:0] trial;
	sqrt_t nxt;

	always_comb begin
		rem2  = {in_sq.rem[33:0], in_sq.rad[31:30]};
		trial = {2'b00, in_sq.root, 2'b01};
		nxt.rad = {in_sq.rad[29:0], 2'b00};
		if (rem2 >= trial) begin
			nxt.rem  = rem2 - trial;
			nxt.root = {in_sq.root[30:0], 1'b1};
		end else begin
			nxt.rem  = rem2;
			nxt.root = {in_sq.root[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		out_sq   <= nxt;
		out_side <= in_side;
	end
endmodule
`default_nettype wire

@@ src/aar_div_cell.sv @@
// One quotient bit of the three axis component divisions by the norm.
`default_nettype none
module aar_div_cell import aar_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_vld,
	input  wire div_t   in_dv,
	input  wire dside_t in_side,
	output logic        out_vld,
	output div_t        out_dv,
	output dside_t      out_side
);
	logic [2:0][32:0] p2;
	div_t nxt;

	always_comb begin
		nxt.r = in_dv.r;
		for (int k = 0; k < 3; k++) begin
			p2[k] = {in_dv.p[k][31:0], 1'b0};
			if (p2[k] >= {1'b0, in_dv.r}) begin
				nxt.p[k] = p2[k] - {1'b0, in_dv.r};
				nxt.q[k] = {in_dv.q[k][29:0], 1'b1};
			end else begin
				nxt.p[k] = p2[k];
				nxt.q[k] = {in_dv.q[k][29:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		out_dv   <= nxt;
		out_side <= in_side;
	end
endmodule
`default_nettype wire

@@ src/aar_cordic_cell.sv @@
// One rotation step of the sine and cosine CORDIC.
`default_nettype none
module aar_cordic_cell import aar_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [4:0] step,
	input  wire logic       in_vld,
	input  wire cord_t      in_c,
	input  wire cside_t     in_side,
	output logic            out_vld,
	output cord_t           out_c,
	output cside_t          out_side
);
	logic signed [32:0] xs;
	logic signed [32:0] ys;
	logic signed [32:0] at;
	cord_t nxt;

	always_comb begin
		xs = in_c.x >>> step;
		ys = in_c.y >>> step;
		at = atan_q30(step);
		if (!in_c.z[32]) begin
			nxt.x = in_c.x - ys;
			nxt.y = in_c.y + xs;
			nxt.z = in_c.z - at;
		end else begin
			nxt.x = in_c.x + ys;
			nxt.y = in_c.y - xs;
			nxt.z = in_c.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		out_c    <= nxt;
		out_side <= in_side;
	end
endmodule
`default_nettype wire

@@ src/aar_matrix_out.sv @@
// Rodrigues products, rounding and saturation into the nine matrix entries.
`default_nettype none
module aar_matrix_out import aar_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_vld,
	input  wire cord_t        in_c,
	input  wire cside_t       in_side,
	output logic              out_vld,
	output logic [8:0][15:0]  out_m,
	output logic              out_zero
);
	logic               vld_s1, vld_s2, vld_s3;
	logic signed [33:0] c_s1, s_s1;
	logic signed [34:0] t_s1;
	logic [2:0][31:0]   u_s1, u_s2;
	logic               zero_s1, zero_s2, zero_s3;
	logic signed [33:0] c_s2, c_s3;
	logic [2:0][36:0]   tu_s2;
	logic [2:0][36:0]   su_s2, su_s3;
	logic [8:0][38:0]   p_s3;
	logic [8:0][15:0]   m;
	logic [15:0]        one_q;
	logic signed [39:0] cw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1    <= in_side.neg ? -34'(in_c.x) : 34'(in_c.x);
		s_s1    <= in_side.neg ? -34'(in_c.y) : 34'(in_c.y);
		t_s1    <= 35'(Q30_ONE) - (in_side.neg ? -35'(in_c.x) : 35'(in_c.x));
		u_s1    <= {in_side.uz, in_side.uy, in_side.ux};
		zero_s1 <= in_side.zero;

		c_s2    <= c_s1;
		u_s2    <= u_s1;
		zero_s2 <= zero_s1;
		for (int k = 0; k < 3; k++) begin
			tu_s2[k] <= 37'(mulq(37'(t_s1), $signed(u_s1[k])));
			su_s2[k] <= 37'(mulq(37'(s_s1), $signed(u_s1[k])));
		end

		c_s3    <= c_s2;
		su_s3   <= su_s2;
		zero_s3 <= zero_s2;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				p_s3[3*i+j] <= mulq($signed(tu_s2[i]), $signed(u_s2[j]));

		out_m    <= m;
		out_zero <= zero_s3;
	end

	// su index: 0 = s*ux, 1 = s*uy, 2 = s*uz; p index 3*col+row
	always_comb begin
		one_q = to_out(40'(Q30_ONE));
		cw    = 40'(c_s3);
		m[0] = to_out(cw + 40'($signed(p_s3[0])));
		m[1] = to_out(40'($signed(p_s3[1])) + 40'($signed(su_s3[2])));
		m[2] = to_out(40'($signed(p_s3[2])) - 40'($signed(su_s3[1])));
		m[3] = to_out(40'($signed(p_s3[3])) - 40'($signed(su_s3[2])));
		m[4] = to_out(cw + 40'($signed(p_s3[4])));
		m[5] = to_out(40'($signed(p_s3[5])) + 40'($signed(su_s3[0])));
		m[6] = to_out(40'($signed(p_s3[6])) + 40'($signed(su_s3[1])));
		m[7] = to_out(40'($signed(p_s3[7])) - 40'($signed(su_s3[0])));
		m[8] = to_out(cw + 40'($signed(p_s3[8])));
		if (zero_s3) begin
			for (int k = 0; k < 9; k++)
				m[k] = (k % 4 == 0) ? one_q : 16'd0;
		end
	end
endmodule
`default_nettype wire

@@ src/axis_angle_rotation_matrix.sv @@
// Top level of the axis-angle rotation matrix pipeline.
// Stages from the accepting edge to the done cycle: 1 input stage, 32 square root
// cells, 31 divider cells, 16 CORDIC cells and 4 product stages.
// Throughput: one item per cycle; busy is held low and the receiver cannot stall.
// Reset: arst_n clears the valid bits of every stage; payload is not reset.
`default_nettype none
module axis_angle_rotation_matrix import aar_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] angle,
	input  wire logic [15:0] axis_x,
	input  wire logic [15:0] axis_y,
	input  wire logic [15:0] axis_z,
	output logic             done,
	output logic [15:0]      col0_row0,
	output logic [15:0]      col0_row1,
	output logic [15:0]      col0_row2,
	output logic [15:0]      col1_row0,
	output logic [15:0]      col1_row1,
	output logic [15:0]      col1_row2,
	output logic [15:0]      col2_row0,
	output logic [15:0]      col2_row1,
	output logic [15:0]      col2_row2,
	output logic             zero_axis
);
	localparam int LAT = 1 + SQRT_CELLS + DIV_CELLS + CORDIC_STEPS + OUT_STAGES;

	logic  sq_vld [0:SQRT_CELLS];
	sqrt_t sq     [0:SQRT_CELLS];
	side_t sqs    [0:SQRT_CELLS];
	logic   dv_vld [0:DIV_CELLS];
	div_t   dv     [0:DIV_CELLS];
	dside_t dvs    [0:DIV_CELLS];
	logic   cr_vld [0:CORDIC_STEPS];
	cord_t  cr     [0:CORDIC_STEPS];
	cside_t crs    [0:CORDIC_STEPS];

	logic signed [32:0] z0;
	logic signed [31:0] sqx, sqy, sqz;
	logic [31:0]        n2;
	side_t              side_in;
	logic [8:0][15:0]   mat;

	assign busy = 1'b0;

	always_comb begin
		z0  = {angle[15], angle, 16'd0} <<< 1;
		sqx = $signed(axis_x) * $signed(axis_x);
		sqy = $signed(axis_y) * $signed(axis_y);
		sqz = $signed(axis_z) * $signed(axis_z);
		n2  = sqx + sqy + sqz;
		side_in.zero = (axis_x == 16'd0) && (axis_y == 16'd0) && (axis_z == 16'd0);
		side_in.sgn  = {axis_z[15], axis_y[15], axis_x[15]};
		side_in.mag[0] = axis_x[15] ? -axis_x : axis_x;
		side_in.mag[1] = axis_y[15] ? -axis_y : axis_y;
		side_in.mag[2] = axis_z[15] ? -axis_z : axis_z;
		if (z0 > HALF_PI_Q30) begin
			side_in.ang = z0 - PI_Q30;
			side_in.neg = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			side_in.ang = z0 + PI_Q30;
			side_in.neg = 1'b1;
		end else begin
			side_in.ang = z0;
			side_in.neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld[0] <= 1'b0;
		else
			sq_vld[0] <= start && !busy;
	end

	always_ff @(posedge clk) begin
		sq[0]  <= '{rem: 36'd0, root: 32'd0, rad: n2};
		sqs[0] <= side_in;
	end

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		aar_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (sq_vld[i]),
			.in_sq    (sq[i]),
			.in_side  (sqs[i]),
			.out_vld  (sq_vld[i+1]),
			.out_sq   (sq[i+1]),
			.out_side (sqs[i+1])
		);
	end

	assign dv_vld[0] = sq_vld[SQRT_CELLS];
	always_comb begin
		dv[0].r = sq[SQRT_CELLS].root;
		for (int k = 0; k < 3; k++) begin
			dv[0].p[k] = {2'b00, sqs[SQRT_CELLS].mag[k], 15'd0};
			dv[0].q[k] = 31'd0;
		end
		dvs[0].ang  = sqs[SQRT_CELLS].ang;
		dvs[0].neg  = sqs[SQRT_CELLS].neg;
		dvs[0].zero = sqs[SQRT_CELLS].zero;
		dvs[0].sgn  = sqs[SQRT_CELLS].sgn;
	end

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		aar_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (dv_vld[i]),
			.in_dv    (dv[i]),
			.in_side  (dvs[i]),
			.out_vld  (dv_vld[i+1]),
			.out_dv   (dv[i+1]),
			.out_side (dvs[i+1])
		);
	end

	assign cr_vld[0] = dv_vld[DIV_CELLS];
	always_comb begin
		cr[0].x = CORDIC_GAIN;
		cr[0].y = 33'sd0;
		cr[0].z = dvs[DIV_CELLS].ang;
		crs[0].ux = dvs[DIV_CELLS].sgn[0] ? -{1'b0, dv[DIV_CELLS].q[0]} :
			{1'b0, dv[DIV_CELLS].q[0]};
		crs[0].uy = dvs[DIV_CELLS].sgn[1] ? -{1'b0, dv[DIV_CELLS].q[1]} :
			{1'b0, dv[DIV_CELLS].q[1]};
		crs[0].uz = dvs[DIV_CELLS].sgn[2] ? -{1'b0, dv[DIV_CELLS].q[2]} :
			{1'b0, dv[DIV_CELLS].q[2]};
		crs[0].neg  = dvs[DIV_CELLS].neg;
		crs[0].zero = dvs[DIV_CELLS].zero;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		aar_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (5'(i)),
			.in_vld   (cr_vld[i]),
			.in_c     (cr[i]),
			.in_side  (crs[i]),
			.out_vld  (cr_vld[i+1]),
			.out_c    (cr[i+1]),
			.out_side (crs[i+1])
		);
	end

	aar_matrix_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (cr_vld[CORDIC_STEPS]),
		.in_c     (cr[CORDIC_STEPS]),
		.in_side  (crs[CORDIC_STEPS]),
		.out_vld  (done),
		.out_m    (mat),
		.out_zero (zero_axis)
	);

	assign col0_row0 = mat[0];
	assign col0_row1 = mat[1];
	assign col0_row2 = mat[2];
	assign col1_row0 = mat[3];
	assign col1_row1 = mat[4];
	assign col1_row2 = mat[5];
	assign col2_row0 = mat[6];
	assign col2_row1 = mat[7];
	assign col2_row2 = mat[8];

`ifndef ASSERT_OFF
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching item");

	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_axis) |-> (col0_row1 == 16'd0 && col1_row2 == 16'd0 &&
			col2_row0 == 16'd0 && col0_row0 == col1_row1 && col1_row1 == col2_row2))
		else $error("zero axis did not give identity");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> sq_vld[0])
		else $error("item dropped at input");
`endif
endmodule
`default_nettype wire

@@ test/axis_angle_rotation_matrix_tb.sv @@
// Testbench for the axis-angle rotation matrix: directed and random items checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module axis_angle_rotation_matrix_tb;
	import aar_pkg::*;

	typedef struct packed {
		logic [8:0][15:0] m;
		logic             zero;
	} matrix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] angle = '0, axis_x = '0, axis_y = '0, axis_z = '0;
	wire         busy, done, zero_axis;
	wire  [15:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;

	matrix_t expected_mats[$];
	int      errors = 0;
	int      idle_pct = 32;

	axis_angle_rotation_matrix dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.done(done),
		.col0_row0(c00), .col0_row1(c01), .col0_row2(c02),
		.col1_row0(c10), .col1_row1(c11), .col1_row2(c12),
		.col2_row0(c20), .col2_row1(c21), .col2_row2(c22),
		.zero_axis(zero_axis)
	);

	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("axis_angle_rotation_matrix test failed");
		$finish;
	end

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic logic [15:0] q14(longint v);
		longint w, lim;
		lim = longint'(1) << FRAC_BITS;
		w = fshift(v + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS);
		if (w > lim) w = lim;
		if (w < -lim) w = -lim;
		return w[15:0];
	endfunction

	function automatic longint qmul(longint a, longint b);
		return fshift(a * b, 30);
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_of(longint a, longint unsigned r);
		longint unsigned mg;
		longint q;
		mg = longint'(a < 0 ? -a : a) << 46;
		q = longint'(mg / r);
		return a < 0 ? -q : q;
	endfunction

	function automatic longint atan_angle(int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			9: return 2097149;
			default: return longint'(1) << (30 - i);
		endcase
	endfunction

	function automatic matrix_t rotation_of(logic [15:0] ang_in, logic [15:0] ax_in,
		logic [15:0] ay_in, logic [15:0] az_in);
		matrix_t e;
		longint ax, ay, az, z, x, y, xs, ys, c, s, ux, uy, uz, t, tx, ty, tz, at;
		longint unsigned n2, r;
		bit neg;
		ax = longint'($signed(ax_in));
		ay = longint'($signed(ay_in));
		az = longint'($signed(az_in));
		e = '0;
		if (ax == 0 && ay == 0 && az == 0) begin
			e.m[0] = q14(Q30_ONE); e.m[4] = q14(Q30_ONE); e.m[8] = q14(Q30_ONE);
			e.zero = 1'b1;
			return e;
		end
		neg = 1'b0;
		z = longint'($signed(ang_in)) * (longint'(1) << 17);
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30; neg = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30; neg = 1'b1;
		end
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = fshift(x, i); ys = fshift(y, i);
			at = longint'(atan_angle(i));
			if (z >= 0) begin
				x -= ys; y += xs; z -= at;
			end else begin
				x += ys; y -= xs; z += at;
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
		n2 = ax * ax + ay * ay + az * az;
		r = isqrt(n2 << 32);
		ux = unit_of(ax, r); uy = unit_of(ay, r); uz = unit_of(az, r);
		t = Q30_ONE - c;
		tx = qmul(t, ux); ty = qmul(t, uy); tz = qmul(t, uz);
		e.m[0] = q14(c + qmul(tx, ux));
		e.m[1] = q14(qmul(tx, uy) + qmul(s, uz));
		e.m[2] = q14(qmul(tx, uz) - qmul(s, uy));
		e.m[3] = q14(qmul(ty, ux) - qmul(s, uz));
		e.m[4] = q14(c + qmul(ty, uy));
		e.m[5] = q14(qmul(ty, uz) + qmul(s, ux));
		e.m[6] = q14(qmul(tz, ux) + qmul(s, uy));
		e.m[7] = q14(qmul(tz, uy) - qmul(s, ux));
		e.m[8] = q14(c + qmul(tz, uz));
		return e;
	endfunction

	task automatic send_item(logic [15:0] a, logic [15:0] x, logic [15:0] y,
		logic [15:0] z);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		angle <= a; axis_x <= x; axis_y <= y; axis_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_mats.push_back(rotation_of(a, x, y, z));
	endtask

	task automatic idle_cycle();
		start <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		matrix_t e;
		logic [8:0][15:0] got;
		if (done) begin
			got = {c22, c21, c20, c12, c11, c10, c02, c01, c00};
			if (expected_mats.size() == 0) begin
				$error("result with no item pending");
				errors++;
			end else begin
				e = expected_mats.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== e.m[k]) begin
						$error("col%0d_row%0d expected %0d actual %0d", k / 3, k % 3,
							$signed(e.m[k]), $signed(got[k]));
						errors++;
					end
				if (zero_axis !== e.zero) begin
					$error("zero_axis expected %0d actual %0d", e.zero, zero_axis);
					errors++;
				end
			end
		end
	end

	function automatic logic [15:0] rand_angle();
		return 16'($signed($urandom_range(51472)) - 25736);
	endfunction

	task automatic test_directed();
		logic [15:0] angs [7] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
			-16'sd12868, 16'h7fff, 16'h8000};
		foreach (angs[i]) send_item(angs[i], 16'd1, 16'd0, 16'd0);
		send_item(16'sd6000, 16'd0, 16'd0, 16'd0);
		send_item(16'h8000, 16'd0, 16'd0, 16'd0);
		send_item(16'sd6000, 16'h7fff, 16'h7fff, 16'h7fff);
		send_item(-16'sd6000, 16'h8000, 16'h8000, 16'h8000);
		send_item(16'sd9000, 16'd0, 16'h8000, 16'd0);
		send_item(16'sd9000, 16'd0, 16'd0, 16'h7fff);
		send_item(-16'sd20000, 16'hffff, 16'd1, 16'hffff);
		send_item(16'sd25736, 16'h8000, 16'h7fff, 16'd0);
		send_item(16'sd3000, 16'd0, 16'd0, 16'd1);
		send_item(16'sd3000, 16'h5555, 16'haaaa, 16'h1234);
	endtask

	task automatic test_random(int n);
		logic [15:0] a, x, y, z;
		for (int i = 0; i < n; i++) begin
			a = ($urandom_range(9) == 0) ? 16'($urandom) : rand_angle();
			case ($urandom_range(4))
				0: begin
					x = 16'($signed($urandom_range(16)) - 8);
					y = 16'($signed($urandom_range(16)) - 8);
					z = 16'($signed($urandom_range(16)) - 8);
				end
				1: begin
					x = 16'($urandom); y = 16'($urandom_range(1)); z = '0;
				end
				default: begin
					x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
				end
			endcase
			if (i == 400) idle_pct = 0;
			if (i == 650) idle_pct = 32;
			send_item(a, x, y, z);
		end
	endtask

	task automatic test_drain_pause();
		idle_cycle();
		while (expected_mats.size() != 0) @(posedge clk);
		repeat (3) send_item(rand_angle(), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600);
		test_drain_pause();
		test_random(680);
		idle_cycle();
		while (expected_mats.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("axis_angle_rotation_matrix test passed");
		else
			$display("axis_angle_rotation_matrix test failed");
		$finish;
	end

endmodule
`default_nettype wire
